// ===== hdl/tlip_pkg.sv =====
// tlip_pkg: shared constants and types for the three-line intersection block.
// No dependencies.
`default_nettype none
package tlip_pkg;
	localparam int COEF_W    = 32;          // coefficient / coordinate width
	localparam int FRAC_BITS = 16;          // fraction bits of the fixed-point format
	localparam int PROD_W    = 2 * COEF_W;  // full product width
	localparam int WIDE_W    = PROD_W + 1;  // difference of two products
	localparam int TOL_W     = 16;          // register field width
	localparam int QDEPTH    = 4;           // job queue depth

	typedef logic signed [COEF_W-1:0] coef_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [WIDE_W-1:0] wide_t;

	// one line pair, ready for division
	typedef struct packed {
		logic  skip;   // degenerate line or parallel pair
		logic  last;   // final pair of its item
		wide_t det;
		wide_t nx;
		wide_t ny;
	} job_t;

	typedef struct packed {
		coef_t x;
		coef_t y;
		logic  ovf;
	} point_t;

	localparam int JOB_W = $bits(job_t);
endpackage
`default_nettype wire

// ===== hdl/tlip_fifo.sv =====
// tlip_fifo: small register FIFO between front and back.
// No package dependencies.
`default_nettype none
module tlip_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      rdata,
	output logic                  not_empty
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [PTR_W:0]   cnt_q;
	logic             do_push, do_pop;

	assign full      = (cnt_q == (PTR_W+1)'(DEPTH));
	assign not_empty = (cnt_q != '0);
	assign rdata     = mem_q[rd_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH-1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH-1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

// ===== hdl/tlip_front.sv =====
// tlip_front: accepts items and forms determinant and numerators, one pair a cycle while the job queue is not full.
// Depends on tlip_pkg.
`default_nettype none
module tlip_front (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire tlip_pkg::coef_t [8:0]    coefs,
	output logic                          job_push,
	output tlip_pkg::job_t                job,
	input  wire logic                     job_full
);
	import tlip_pkg::*;

	coef_t      item_q [9];
	logic       busy_q;
	logic [1:0] pair_q;
	logic       en, issue;
	coef_t      a1, b1, c1, a2, b2, c2;

	logic  v_s1, skip_s1, last_s1;
	prod_t d1_s1, d2_s1, x1_s1, x2_s1, y1_s1, y2_s1;
	logic  v_s2;
	job_t  job_s2;
	wide_t det_w;

	assign en       = !v_s2 || !job_full;
	assign issue    = busy_q && en;
	assign in_ready = !busy_q || (en && pair_q == 2'd2);
	assign job_push = v_s2 && !job_full;
	assign job      = job_s2;

	// pairs (1,2), (1,3), (2,3)
	always_comb begin
		unique case (pair_q)
			2'd0: begin
				a1 = item_q[0]; b1 = item_q[1]; c1 = item_q[2];
				a2 = item_q[3]; b2 = item_q[4]; c2 = item_q[5];
			end
			2'd1: begin
				a1 = item_q[0]; b1 = item_q[1]; c1 = item_q[2];
				a2 = item_q[6]; b2 = item_q[7]; c2 = item_q[8];
			end
			default: begin
				a1 = item_q[3]; b1 = item_q[4]; c1 = item_q[5];
				a2 = item_q[6]; b2 = item_q[7]; c2 = item_q[8];
			end
		endcase
	end

	assign det_w = {d1_s1[PROD_W-1], d1_s1} - {d2_s1[PROD_W-1], d2_s1};

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			for (int i = 0; i < 9; i++) begin
				item_q[i] <= coefs[i];
			end
		end
		if (en) begin
			d1_s1   <= a1 * b2;
			d2_s1   <= a2 * b1;
			x1_s1   <= b1 * c2;
			x2_s1   <= b2 * c1;
			y1_s1   <= a2 * c1;
			y2_s1   <= a1 * c2;
			skip_s1 <= (a1 == '0 && b1 == '0) || (a2 == '0 && b2 == '0);
			last_s1 <= (pair_q == 2'd2);
			job_s2.det  <= det_w;
			job_s2.nx   <= {x1_s1[PROD_W-1], x1_s1} - {x2_s1[PROD_W-1], x2_s1};
			job_s2.ny   <= {y1_s1[PROD_W-1], y1_s1} - {y2_s1[PROD_W-1], y2_s1};
			job_s2.skip <= skip_s1 || (det_w == '0);
			job_s2.last <= last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pair_q <= 2'd0;
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				busy_q <= 1'b1;
				pair_q <= 2'd0;
			end else if (issue) begin
				if (pair_q == 2'd2) begin
					busy_q <= 1'b0;
				end else begin
					pair_q <= pair_q + 2'd1;
				end
			end
			if (en) begin
				v_s1 <= issue;
				v_s2 <= v_s1;
			end
		end
	end
endmodule
`default_nettype wire

// ===== hdl/tlip_div.sv =====
// tlip_div: saturating signed divider, (num << FRAC_BITS) / den, two quotient bits a cycle.
// Depends on tlip_pkg.
`default_nettype none
module tlip_div (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire tlip_pkg::wide_t  num,
	input  wire tlip_pkg::wide_t  den,
	output logic                  done,
	output tlip_pkg::coef_t       quo,
	output logic                  ovf
);
	import tlip_pkg::*;

	localparam int STEPS = COEF_W / 2;
	localparam int CNT_W = $clog2(STEPS);

	logic              run_q, fin_q, done_q, neg_q, big_q, ovf_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [WIDE_W-1:0] d_q, r_q;
	logic [COEF_W-1:0] l_q, q_q;
	coef_t             quo_q;

	logic [WIDE_W-1:0] n_abs, d_abs, hi;
	logic [WIDE_W:0]   t1, t2;
	logic [WIDE_W-1:0] r1, r2;
	logic              ge1, ge2;
	logic [COEF_W:0]   lim;
	logic [COEF_W-1:0] qm;

	assign n_abs = num[WIDE_W-1] ? WIDE_W'(-num) : WIDE_W'(num);
	assign d_abs = den[WIDE_W-1] ? WIDE_W'(-den) : WIDE_W'(den);
	assign hi    = n_abs >> (COEF_W - FRAC_BITS);

	assign t1  = {r_q, l_q[COEF_W-1]};
	assign ge1 = t1 >= {1'b0, d_q};
	assign r1  = ge1 ? WIDE_W'(t1 - {1'b0, d_q}) : WIDE_W'(t1);
	assign t2  = {r1, l_q[COEF_W-2]};
	assign ge2 = t2 >= {1'b0, d_q};
	assign r2  = ge2 ? WIDE_W'(t2 - {1'b0, d_q}) : WIDE_W'(t2);

	// magnitude limit: 2^(W-1) for a negative quotient, 2^(W-1)-1 otherwise
	assign lim = ((COEF_W+1)'(1) << (COEF_W - 1)) - (neg_q ? '0 : (COEF_W+1)'(1));
	assign qm  = (big_q || {1'b0, q_q} > lim) ? lim[COEF_W-1:0] : q_q;

	assign done = done_q;
	assign quo  = quo_q;
	assign ovf  = ovf_q;

	always_ff @(posedge clk) begin
		if (start && !run_q) begin
			d_q   <= d_abs;
			r_q   <= hi;
			l_q   <= COEF_W'(n_abs << FRAC_BITS);
			neg_q <= num[WIDE_W-1] != den[WIDE_W-1];
			big_q <= hi >= d_abs;
			cnt_q <= '0;
		end else if (run_q) begin
			r_q   <= r2;
			l_q   <= l_q << 2;
			q_q   <= {q_q[COEF_W-3:0], ge1, ge2};
			cnt_q <= cnt_q + 1'b1;
		end
		if (fin_q) begin
			quo_q <= neg_q ? coef_t'(-qm) : coef_t'(qm);
			ovf_q <= big_q || ({1'b0, q_q} > lim);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= fin_q;
			fin_q  <= run_q && (cnt_q == CNT_W'(STEPS - 1));
			if (start && !run_q) begin
				run_q <= 1'b1;
			end else if (run_q && cnt_q == CNT_W'(STEPS - 1)) begin
				run_q <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire

// ===== hdl/tlip_back.sv =====
// tlip_back: divides queued pairs, merges and sorts points, and sends the results.
// Depends on tlip_pkg and tlip_div.
`default_nettype none
module tlip_back (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         job_valid,
	input  wire tlip_pkg::job_t               job,
	output logic                              job_pop,
	input  wire logic [tlip_pkg::TOL_W-1:0]   tol,
	input  wire logic [tlip_pkg::TOL_W-1:0]   snap,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [1:0]                        point_count,
	output logic                              has_point,
	output tlip_pkg::coef_t                   point_x,
	output tlip_pkg::coef_t                   point_y,
	output logic                              overflow,
	output logic                              last
);
	import tlip_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_SORT = 2'd2;
	localparam logic [1:0] ST_HAND = 2'd3;

	logic [1:0] state_q, sort_q, cnt_q;
	logic       last_q;
	point_t     pts_q [3];

	logic       emit_q;
	logic [1:0] ecnt_q, eidx_q;
	point_t     epts_q [3];

	logic   start, xdone, ydone, xovf, yovf, match, swap, pair_done;
	coef_t  xq, yq;
	point_t cand, pi, pj, cur;
	logic [1:0] si, sj;

	tlip_div u_divx (
		.clk(clk), .arst_n(arst_n), .start(start), .num(job.nx), .den(job.det),
		.done(xdone), .quo(xq), .ovf(xovf)
	);
	tlip_div u_divy (
		.clk(clk), .arst_n(arst_n), .start(start), .num(job.ny), .den(job.det),
		.done(ydone), .quo(yq), .ovf(yovf)
	);

	assign job_pop   = (state_q == ST_IDLE) && job_valid;
	assign start     = job_pop && !job.skip;
	assign pair_done = xdone && ydone;

	assign cand.x   = xq;
	assign cand.y   = yq;
	assign cand.ovf = xovf || yovf;

	always_comb begin
		match = 1'b0;
		for (int i = 0; i < 3; i++) begin
			if (2'(i) < cnt_q && pts_q[i].x == cand.x && pts_q[i].y == cand.y) begin
				match = 1'b1;
			end
		end
	end

	always_comb begin
		unique case (sort_q)
			2'd0:    begin si = 2'd0; sj = 2'd1; end
			2'd1:    begin si = 2'd0; sj = 2'd2; end
			default: begin si = 2'd1; sj = 2'd2; end
		endcase
		pi = pts_q[si];
		pj = pts_q[sj];
	end

	function automatic logic need_swap(point_t a, point_t b, logic [TOL_W-1:0] t);
		logic signed [COEF_W:0] dx, dy, adx, ts;
		dx  = {a.x[COEF_W-1], a.x} - {b.x[COEF_W-1], b.x};
		dy  = {a.y[COEF_W-1], a.y} - {b.y[COEF_W-1], b.y};
		adx = (dx < 0) ? -dx : dx;
		ts  = $signed((COEF_W+1)'(t));
		return (dx > ts) || (adx < ts && dy > ts);
	endfunction

	function automatic coef_t snap_val(coef_t v, logic [TOL_W-1:0] s);
		logic [COEF_W:0] m;
		m = v[COEF_W-1] ? (COEF_W+1)'(-{v[COEF_W-1], v}) : (COEF_W+1)'(v);
		return (m < (COEF_W+1)'(s)) ? coef_t'(0) : v;
	endfunction

	assign swap = (sj < cnt_q) && need_swap(pi, pj, tol);

	// result side
	assign cur         = epts_q[eidx_q];
	assign out_valid   = emit_q;
	assign point_count = ecnt_q;
	assign has_point   = (ecnt_q != 2'd0);
	assign point_x     = has_point ? snap_val(cur.x, snap) : '0;
	assign point_y     = has_point ? snap_val(cur.y, snap) : '0;
	assign overflow    = has_point && cur.ovf;
	assign last        = (ecnt_q == 2'd0) || (eidx_q == ecnt_q - 2'd1);

	always_ff @(posedge clk) begin
		if (state_q == ST_DIV && pair_done && !match) begin
			pts_q[cnt_q] <= cand;
		end
		if (state_q == ST_SORT && swap) begin
			pts_q[si] <= pj;
			pts_q[sj] <= pi;
		end
		if (state_q == ST_HAND && !emit_q) begin
			for (int i = 0; i < 3; i++) begin
				epts_q[i] <= pts_q[i];
			end
			ecnt_q <= cnt_q;
		end
		if (job_pop) begin
			last_q <= job.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sort_q  <= 2'd0;
			cnt_q   <= 2'd0;
			emit_q  <= 1'b0;
			eidx_q  <= 2'd0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						if (!job.skip) begin
							state_q <= ST_DIV;
						end else if (job.last) begin
							state_q <= ST_SORT;
						end
					end
				end
				ST_DIV: begin
					if (pair_done) begin
						if (!match) begin
							cnt_q <= cnt_q + 2'd1;
						end
						state_q <= last_q ? ST_SORT : ST_IDLE;
					end
				end
				ST_SORT: begin
					if (sort_q == 2'd2) begin
						sort_q  <= 2'd0;
						state_q <= ST_HAND;
					end else begin
						sort_q <= sort_q + 2'd1;
					end
				end
				default: begin
					if (!emit_q) begin
						cnt_q   <= 2'd0;
						state_q <= ST_IDLE;
					end
				end
			endcase

			if (state_q == ST_HAND && !emit_q) begin
				emit_q <= 1'b1;
				eidx_q <= 2'd0;
			end else if (emit_q && out_ready) begin
				if (last) begin
					emit_q <= 1'b0;
				end else begin
					eidx_q <= eidx_q + 2'd1;
				end
			end
		end
	end
endmodule
`default_nettype wire

// ===== hdl/three_line_intersection_points_top.sv =====
// three_line_intersection_points_top: top level, config registers, front/queue/back.
// Depends on tlip_pkg, tlip_front, tlip_fifo, tlip_back.
//
//  channel   | direction | handshake          | payload
//  ----------+-----------+--------------------+----------------------------------------
//  in        | to block  | in_valid/in_ready  | l1..l3 x_coef, y_coef, const (Q16.16)
//  out       | from blk  | out_valid/out_ready| point_count, has_point, point_x/y, ...
//  apb       | to block  | psel/penable/pready| paddr, pwdata, prdata (0: tol, 4: snap)
//
// Flow: the front takes an item and issues its three line pairs, one line pair a cycle
// through six 32x32 multipliers while the job queue is not full. The back runs two dividers
// (x and y) at two quotient bits a cycle on each solvable pair, pops a skipped pair
// without dividing, then sorts and hands off the points; the dividers set the rate.
// Reset: arst_n clears all control state; registers return to tol 1, snap 66.
// Stalls: a 4-entry job queue decouples front and back; an emit buffer holds results.
`default_nettype none
module three_line_intersection_points_top #(
	parameter int QUEUE_DEPTH = tlip_pkg::QDEPTH
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire tlip_pkg::coef_t         l1_x_coef,
	input  wire tlip_pkg::coef_t         l1_y_coef,
	input  wire tlip_pkg::coef_t         l1_const,
	input  wire tlip_pkg::coef_t         l2_x_coef,
	input  wire tlip_pkg::coef_t         l2_y_coef,
	input  wire tlip_pkg::coef_t         l2_const,
	input  wire tlip_pkg::coef_t         l3_x_coef,
	input  wire tlip_pkg::coef_t         l3_y_coef,
	input  wire tlip_pkg::coef_t         l3_const,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output logic [1:0]                   point_count,
	output logic                         has_point,
	output tlip_pkg::coef_t              point_x,
	output tlip_pkg::coef_t              point_y,
	output logic                         overflow,
	output logic                         last,
	input  wire logic                    psel,
	input  wire logic                    penable,
	input  wire logic                    pwrite,
	input  wire logic [2:0]              paddr,
	input  wire logic [31:0]             pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);
	import tlip_pkg::*;

	localparam logic REG_TOL  = 1'b0;
	localparam logic REG_SNAP = 1'b1;

	logic [TOL_W-1:0] tol_q, snap_q;
	coef_t [8:0]      coefs;
	logic             job_push, job_full, job_pop, job_valid;
	job_t             job_in, job_out;

	// APB registers; byte address bit 2 picks the register
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_SNAP) ? 32'(snap_q) : 32'(tol_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q  <= TOL_W'(1);
			snap_q <= TOL_W'(66);
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				REG_TOL:  tol_q  <= pwdata[TOL_W-1:0];
				default:  snap_q <= pwdata[TOL_W-1:0];
			endcase
		end
	end

	assign coefs[0] = l1_x_coef;
	assign coefs[1] = l1_y_coef;
	assign coefs[2] = l1_const;
	assign coefs[3] = l2_x_coef;
	assign coefs[4] = l2_y_coef;
	assign coefs[5] = l2_const;
	assign coefs[6] = l3_x_coef;
	assign coefs[7] = l3_y_coef;
	assign coefs[8] = l3_const;

	tlip_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.coefs(coefs), .job_push(job_push), .job(job_in), .job_full(job_full)
	);

	tlip_fifo #(.WIDTH(JOB_W), .DEPTH(QUEUE_DEPTH)) u_queue (
		.clk(clk), .arst_n(arst_n), .push(job_push), .wdata(job_in), .full(job_full),
		.pop(job_pop), .rdata(job_out), .not_empty(job_valid)
	);

	tlip_back u_back (
		.clk(clk), .arst_n(arst_n), .job_valid(job_valid), .job(job_out),
		.job_pop(job_pop), .tol(tol_q), .snap(snap_q),
		.out_valid(out_valid), .out_ready(out_ready), .point_count(point_count),
		.has_point(has_point), .point_x(point_x), .point_y(point_y),
		.overflow(overflow), .last(last)
	);

	// a result carries a point exactly when its item has points
	a_has_point: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (has_point == (point_count != 2'd0)))
		else $error("has_point disagrees with point_count");

	// the empty result is alone and carries zero coordinates
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !has_point) |-> (last && point_x == '0 && point_y == '0 && !overflow))
		else $error("malformed empty result");

	// a single point is always the last of its item
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && point_count == 2'd1) |-> last)
		else $error("single point not marked last");
endmodule
`default_nettype wire

// ===== test/tb.sv =====
// tb: self-checking testbench for three_line_intersection_points_top.
// Depends on tlip_pkg and the block's RTL; predicts every result in SystemVerilog.
`timescale 1ns / 100ps
`default_nettype none
module tb;
	import tlip_pkg::*;

	// register map, byte addresses
	localparam logic [2:0] ADDR_SORT_TOL  = 3'd0;
	localparam logic [2:0] ADDR_ZERO_SNAP = 3'd4;
	localparam int         DRAIN_CYCLES   = 100;  // covers the slowest item in the back end
	localparam coef_t      ONE            = 32'sd65536;

	typedef logic signed [127:0] w128_t;

	// one result as it should appear on the output channel
	typedef struct {
		logic [1:0] cnt;
		logic       has;
		coef_t      x;
		coef_t      y;
		logic       ovf;
		logic       lst;
	} isec_t;

	typedef struct {
		longint x;
		longint y;
		logic   ovf;
	} sol_t;

	logic clk = 0, arst_n = 0;
	logic in_valid = 0, out_ready = 0;
	coef_t l1_x_coef = 0, l1_y_coef = 0, l1_const = 0;
	coef_t l2_x_coef = 0, l2_y_coef = 0, l2_const = 0;
	coef_t l3_x_coef = 0, l3_y_coef = 0, l3_const = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [2:0]  paddr = 0;
	logic [31:0] pwdata = 0;
	logic        in_ready, out_valid, has_point, overflow, last, pready;
	logic [1:0]  point_count;
	coef_t       point_x, point_y;
	logic [31:0] prdata;

	three_line_intersection_points_top u_top (.*);

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	// predictor copy of the registers
	longint sort_tol = 1, snap_lim = 66;

	isec_t  pending_pts[$];
	int     n_items = 0, n_results = 0, n_points = 0, n_ovf = 0, n_empty = 0;
	int     n_errors = 0;
	int     gap_pct = 0, stall_pct = 0;
	int     hold_start = 0, hold_left = 0;

	// ---------------------------------------------------------------- predictor
	function automatic w128_t wmul(input coef_t a, input coef_t b);
		w128_t wa = w128_t'(a), wb = w128_t'(b);
		return wa * wb;
	endfunction

	// truncated (num << FRAC_BITS) / den, clamped to the coordinate range
	function automatic longint qdiv(input w128_t num, input w128_t den, inout logic ovf);
		w128_t n = num <<< FRAC_BITS;
		logic  nn = n < 0, dn = den < 0;
		w128_t na = nn ? -n : n;
		w128_t da = dn ? -den : den;
		w128_t q  = na / da;
		w128_t lim = (w128_t'(1) <<< (COEF_W - 1)) - ((nn != dn) ? 0 : 1);
		if (q > lim) begin
			ovf = 1;
			q = lim;
		end
		return (nn != dn) ? -longint'(q) : longint'(q);
	endfunction

	function automatic logic cramer(input coef_t a1, b1, c1, a2, b2, c2, output sol_t s);
		w128_t det, nx, ny;
		s = '{0, 0, 0};
		if ((a1 == 0 && b1 == 0) || (a2 == 0 && b2 == 0))
			return 0;
		det = wmul(a1, b2) - wmul(a2, b1);
		if (det == 0)
			return 0;
		nx = wmul(b1, c2) - wmul(b2, c1);
		ny = wmul(a2, c1) - wmul(a1, c2);
		s.x = qdiv(nx, det, s.ovf);
		s.y = qdiv(ny, det, s.ovf);
		return 1;
	endfunction

	function automatic coef_t snapped(input longint v);
		longint m = v < 0 ? -v : v;
		return (m < snap_lim) ? coef_t'(0) : coef_t'(v);
	endfunction

	// all intersections of one item, merged, sorted and queued as results
	function automatic void predict_points(input coef_t c[9]);
		sol_t pts[3], cand, t;
		int   cnt = 0, dup;
		int   pa[3] = '{0, 0, 1};
		int   pb[3] = '{1, 2, 2};
		longint dx, dy, adx;
		for (int k = 0; k < 3; k++) begin
			if (!cramer(c[3*pa[k]], c[3*pa[k]+1], c[3*pa[k]+2],
			            c[3*pb[k]], c[3*pb[k]+1], c[3*pb[k]+2], cand))
				continue;
			dup = 0;
			for (int j = 0; j < cnt; j++)
				if (pts[j].x == cand.x && pts[j].y == cand.y)
					dup = 1;
			if (!dup) begin
				pts[cnt] = cand;
				cnt++;
			end
		end
		for (int i = 0; i < cnt; i++)
			for (int j = i + 1; j < cnt; j++) begin
				dx = pts[i].x - pts[j].x;
				dy = pts[i].y - pts[j].y;
				adx = dx < 0 ? -dx : dx;
				if (dx > sort_tol || (adx < sort_tol && dy > sort_tol)) begin
					t = pts[i];
					pts[i] = pts[j];
					pts[j] = t;
				end
			end
		if (cnt == 0) begin
			pending_pts.push_back('{2'd0, 1'b0, 32'sd0, 32'sd0, 1'b0, 1'b1});
			n_empty++;
		end
		for (int k = 0; k < cnt; k++) begin
			pending_pts.push_back('{cnt[1:0], 1'b1, snapped(pts[k].x), snapped(pts[k].y),
			                       pts[k].ovf, k == cnt - 1});
			n_points++;
			if (pts[k].ovf)
				n_ovf++;
		end
	endfunction

	// ---------------------------------------------------------------- result checker
	always @(posedge clk) begin
		isec_t e;
		if (arst_n && out_valid && out_ready) begin
			n_results++;
			if (pending_pts.size() == 0) begin
				n_errors++;
				if (n_errors <= 10)
					$display("ERROR: unexpected result x=%0d y=%0d", point_x, point_y);
			end else begin
				e = pending_pts.pop_front();
				if (point_count !== e.cnt || has_point !== e.has || point_x !== e.x ||
				    point_y !== e.y || overflow !== e.ovf || last !== e.lst) begin
					n_errors++;
					if (n_errors <= 10)
						$display("ERROR: result %0d exp cnt=%0d has=%0d x=%0d y=%0d ovf=%0d last=%0d, got cnt=%0d has=%0d x=%0d y=%0d ovf=%0d last=%0d",
						         n_results, e.cnt, e.has, e.x, e.y, e.ovf, e.lst,
						         point_count, has_point, point_x, point_y, overflow, last);
				end
			end
		end
	end

	// receiver: random stalls, plus a long hold-off when a test asks for one
	always @(negedge clk) begin
		if (hold_start != 0) begin
			hold_left = hold_start;
			hold_start = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 0;
		end else
			out_ready <= ($urandom_range(99) >= stall_pct);
	end

	// ---------------------------------------------------------------- drivers
	// offer one item; valid stays up across back-to-back items
	task automatic send_lines(input coef_t c[9]);
		int gap = 0;
		while ($urandom_range(99) < gap_pct)
			gap++;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1;
		{l1_x_coef, l1_y_coef, l1_const} <= {c[0], c[1], c[2]};
		{l2_x_coef, l2_y_coef, l2_const} <= {c[3], c[4], c[5]};
		{l3_x_coef, l3_y_coef, l3_const} <= {c[6], c[7], c[8]};
		do @(posedge clk); while (!in_ready);
		predict_points(c);
		n_items++;
	endtask

	task automatic stop_sending();
		@(negedge clk);
		in_valid <= 0;
	endtask

	task automatic wait_drained();
		while (pending_pts.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// APB write with a readback check
	task automatic reg_write(input logic [2:0] addr, input logic [15:0] val);
		@(negedge clk);
		{psel, penable, pwrite, paddr, pwdata} <= {1'b1, 1'b0, 1'b1, addr, 16'd0, val};
		@(negedge clk);
		penable <= 1;
		@(negedge clk);
		{psel, penable, pwrite} <= 3'b100;
		@(negedge clk);
		penable <= 1;
		@(posedge clk);
		if (prdata[15:0] !== val) begin
			n_errors++;
			if (n_errors <= 10)
				$display("ERROR: readback addr %0d exp %0d got %0d", addr, val, prdata);
		end
		@(negedge clk);
		{psel, penable} <= 2'b00;
		if (addr == ADDR_SORT_TOL)
			sort_tol = longint'(val);
		else
			snap_lim = longint'(val);
	endtask

	task automatic set_regs(input logic [15:0] tol, input logic [15:0] snap);
		wait_drained();
		reg_write(ADDR_SORT_TOL, tol);
		reg_write(ADDR_ZERO_SNAP, snap);
	endtask

	// ---------------------------------------------------------------- line generators
	function automatic coef_t small_q(input int span);
		return coef_t'(($urandom_range(2 * span) - span) * ONE);
	endfunction

	// three lines, one random shape per item
	function automatic void make_lines(output coef_t c[9]);
		int     shape = $urandom_range(99);
		longint px = longint'($urandom_range(40)) - 20;
		longint py = longint'($urandom_range(40)) - 20;
		longint a, b;
		for (int i = 0; i < 9; i++)
			c[i] = (shape < 20) ? coef_t'($urandom) : small_q(12);
		for (int l = 0; l < 3; l++) begin
			if (shape >= 20 && shape < 45) begin
				// all through (px, py): exercises merging
				a = longint'($urandom_range(16)) - 8;
				b = longint'($urandom_range(16)) - 8;
				c[3*l] = coef_t'(a * ONE);
				c[3*l+1] = coef_t'(b * ONE);
				c[3*l+2] = coef_t'(-(a * px + b * py) * ONE);
			end
		end
		if (shape >= 45 && shape < 55) begin
			// line three parallel to line one
			c[6] = c[0] * 2;
			c[7] = c[1] * 2;
		end else if (shape >= 55 && shape < 62) begin
			c[3*$urandom_range(2)] = 0;
			c[3*$urandom_range(2)+1] = 0;
		end else if (shape >= 62 && shape < 72) begin
			// steep lines near the origin: small coordinates for snapping
			c[0] = coef_t'($urandom_range(65535) * ONE);
			c[2] = coef_t'($urandom_range(400) - 200);
			c[4] = coef_t'($urandom_range(65535) * ONE);
			c[5] = coef_t'($urandom_range(400) - 200);
		end else if (shape >= 72 && shape < 78) begin
			// nearly parallel: tiny determinant, saturation
			c[3] = c[0] + 1;
			c[4] = c[1];
		end
	endfunction

	// ---------------------------------------------------------------- tests
	task automatic test_directed();
		coef_t MX = 32'sh7fffffff, MN = 32'sh80000000;
		coef_t dir[12][9] = '{
			'{0, 0, 0, 0, 0, 0, 0, 0, 0},                             // all degenerate
			'{MX, MX, MX, MX, MX, MX, MX, MX, MX},                    // identical lines
			'{MN, MN, MN, MN, MN, MN, MN, MN, MN},
			'{MX, MN, MX, MN, MX, MN, MX, 0, MN},                     // extreme mix
			'{MN, 0, MX, 0, MN, MN, MX, MX, 0},
			'{ONE, 0, -ONE, 0, ONE, -ONE, ONE, ONE, -2*ONE},          // concurrent: one point
			'{ONE, 0, 0, 0, ONE, 0, ONE, -ONE, ONE},                  // three points
			'{ONE, ONE, 0, 2*ONE, 2*ONE, ONE, 0, ONE, 0},             // a parallel pair
			'{0, 0, ONE, ONE, 0, 0, 0, ONE, 0},                       // one degenerate line
			'{1, 0, MX, 0, 1, MN, 1, 1, 0},                           // saturating quotients
			'{ONE, 1, 0, ONE, 0, 0, 0, ONE, 3},                       // tiny coordinates
			'{ONE, 0, -3, 0, ONE, 5, ONE, ONE, 7}                     // ties within tolerance
		};
		foreach (dir[i])
			send_lines(dir[i]);
		stop_sending();
	endtask

	task automatic test_random(input int count, input int gap, input int stall);
		coef_t c[9];
		gap_pct = gap;
		stall_pct = stall;
		repeat (count) begin
			make_lines(c);
			send_lines(c);
		end
		stop_sending();
	endtask

	// receiver holds off long enough to fill the job queue and stall the input
	task automatic test_backpressure();
		coef_t c[9];
		gap_pct = 0;
		stall_pct = 0;
		@(negedge clk);
		hold_start = 400;
		repeat (30) begin
			make_lines(c);
			send_lines(c);
		end
		stop_sending();
	endtask

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		test_directed();                       // reset values of the registers
		set_regs(16'd0, 16'd0);
		test_directed();
		test_random(100, 0, 0);
		set_regs(16'hffff, 16'hffff);
		test_directed();
		test_random(100, 58, 0);
		set_regs(16'd1, 16'd66);
		test_random(100, 0, 58);
		set_regs(16'($urandom), 16'($urandom_range(2000)));
		test_random(100, 24, 24);
		test_backpressure();
		set_regs(16'd2, 16'd300);
		test_random(50, 0, 0);
		wait_drained();
		$display("Covered %0d items, %0d points (%0d saturated), %0d empty results,",
		         n_items, n_points, n_ovf, n_empty);
		$display("across five register settings, idle/stall mixes and a long output hold-off.");
		if (n_errors == 0)
			$display("TEST PASSED");
		else begin
			$display("%0d mismatches", n_errors);
			$display("TEST FAILED");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("timeout, %0d results outstanding", pending_pts.size());
		$display("TEST FAILED");
		$finish;
	end
endmodule
`default_nettype wire
